FILE: hdl/tasdm_pkg.sv
// ----------------------------------------------------------------------------
// tasdm_pkg
// Shared types and constants for the timed actuator sequencer and drive mixer.
// ----------------------------------------------------------------------------
package tasdm_pkg;

  localparam int POT_W     = 10;
  localparam int TIME_W    = 32;
  localparam int DUTY_W    = 8;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WIND   = 3'd1,
    PH_SHUNT  = 3'd2,
    PH_UNWIND = 3'd3,
    PH_PRIMED = 3'd4
  } phase_t;

  typedef logic [1:0] dir_t;

  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_FWD  = 2'd1;
  localparam dir_t DIR_REV  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_WIND   = 2'd0;
  localparam cfg_idx_t REG_SHUNT  = 2'd1;
  localparam cfg_idx_t REG_UNWIND = 2'd2;

  localparam logic [TIME_W-1:0] WIND_RESET   = 32'd24400;
  localparam logic [TIME_W-1:0] SHUNT_RESET  = 32'd1900;
  localparam logic [TIME_W-1:0] UNWIND_RESET = 32'd24200;

  typedef struct packed {
    dir_t              left_dir;
    logic [DUTY_W-1:0] left_duty;
    dir_t              right_dir;
    logic [DUTY_W-1:0] right_duty;
  } drive_t;

endpackage

FILE: hdl/tasdm_mixer.sv
// ----------------------------------------------------------------------------
// tasdm_mixer
// Maps two pot readings to signed throttle and turn, mixes them into left and
// right wheel speeds, clamps and splits each into direction and duty.
// ----------------------------------------------------------------------------
module tasdm_mixer #(
  parameter int POT_FULL_SCALE  = 1023,
  parameter int DUTY_FULL_SCALE = 255
) (
  input  logic [tasdm_pkg::POT_W-1:0] throttle_pot,
  input  logic [tasdm_pkg::POT_W-1:0] turn_pot,
  output tasdm_pkg::drive_t           drive
);
  import tasdm_pkg::*;

  localparam int RSH = POT_W + 16;
  localparam longint unsigned MUL_K =
    ((longint'(2 * DUTY_FULL_SCALE) << RSH) + longint'(POT_FULL_SCALE) - 1) /
    longint'(POT_FULL_SCALE);
  localparam int QMAX   = ((2 ** POT_W) - 1) * 2 * DUTY_FULL_SCALE / POT_FULL_SCALE;
  localparam int QW     = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int DW     = $clog2(DUTY_FULL_SCALE + 1);
  localparam int BW     = (QW > DW) ? QW : DW;
  localparam int SW     = (BW + 2 > DUTY_W + 1) ? BW + 2 : DUTY_W + 1;
  localparam int PROD_W = RSH + QW;

  localparam logic [PROD_W-1:0]   MUL_K_V = PROD_W'(MUL_K);
  localparam logic signed [SW-1:0] DMAX   = SW'(DUTY_FULL_SCALE);
  localparam logic signed [SW-1:0] DMIN   = -DMAX;

  logic [PROD_W-1:0]    thr_prod;
  logic [PROD_W-1:0]    trn_prod;
  logic [QW-1:0]        thr_q;
  logic [QW-1:0]        trn_q;
  logic signed [SW-1:0] thr_s;
  logic signed [SW-1:0] trn_s;
  logic signed [SW-1:0] left_s;
  logic signed [SW-1:0] right_s;

  function automatic logic signed [SW-1:0] clamp_speed(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    if (s > DMAX) begin
      r = DMAX;
    end else if (s < DMIN) begin
      r = DMIN;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic dir_t speed_dir(input logic signed [SW-1:0] s);
    dir_t d;
    if (s > 0) begin
      d = DIR_FWD;
    end else if (s < 0) begin
      d = DIR_REV;
    end else begin
      d = DIR_STOP;
    end
    return d;
  endfunction

  function automatic logic [DUTY_W-1:0] speed_duty(input logic signed [SW-1:0] s);
    logic [SW-1:0] mag;
    mag = (s < 0) ? unsigned'(-s) : unsigned'(s);
    return mag[DUTY_W-1:0];
  endfunction

  assign thr_prod = PROD_W'(throttle_pot) * MUL_K_V;
  assign trn_prod = PROD_W'(turn_pot) * MUL_K_V;
  assign thr_q    = thr_prod[PROD_W-1 -: QW];
  assign trn_q    = trn_prod[PROD_W-1 -: QW];
  assign thr_s    = signed'(SW'(thr_q)) - DMAX;
  assign trn_s    = signed'(SW'(trn_q)) - DMAX;
  assign left_s   = clamp_speed(thr_s + trn_s);
  assign right_s  = clamp_speed(thr_s - trn_s);

  always_comb begin
    drive.left_dir   = speed_dir(left_s);
    drive.left_duty  = speed_duty(left_s);
    drive.right_dir  = speed_dir(right_s);
    drive.right_duty = speed_duty(right_s);
  end

endmodule

FILE: hdl/timed_actuator_sequencer_with_drive_mix.sv
// ----------------------------------------------------------------------------
// timed_actuator_sequencer_with_drive_mix
// Latch sequencer (idle, wind, shunt, unwind, primed) on millisecond timers,
// with a differential drive mixer active while idle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | pots, start, release, time_now
//  out_    | output    | out_valid/stall  | phase, primed, pin levels, drives
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data (durations)
//
//  Each transaction passes two registers: input register, then result register.
//  A new transaction is taken every cycle unless in_stall is high; the result register holds state.
//  in_stall rises only while a transaction waits and out_stall holds a result.
//  cfg_ready is always high; reset restores the default durations.
// ----------------------------------------------------------------------------
module timed_actuator_sequencer_with_drive_mix #(
  parameter int POT_FULL_SCALE  = 1023,
  parameter int DUTY_FULL_SCALE = 255
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tasdm_pkg::POT_W-1:0]         in_throttle_pot,
  input  logic [tasdm_pkg::POT_W-1:0]         in_turn_pot,
  input  logic                                in_start_button,
  input  logic                                in_release_button,
  input  logic [tasdm_pkg::TIME_W-1:0]        in_time_now,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_phase_out,
  output logic                                out_primed_out,
  output logic                                out_magnet_on,
  output logic                                out_latch_forward,
  output logic                                out_latch_backward,
  output logic [1:0]                          out_left_direction,
  output logic [tasdm_pkg::DUTY_W-1:0]        out_left_duty,
  output logic [1:0]                          out_right_direction,
  output logic [tasdm_pkg::DUTY_W-1:0]        out_right_duty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tasdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tasdm_pkg::TIME_W-1:0]        cfg_data
);
  import tasdm_pkg::*;

  logic              s1_valid_r;
  logic [POT_W-1:0]  thr_r;
  logic [POT_W-1:0]  trn_r;
  logic              start_r;
  logic              rel_r;
  logic [TIME_W-1:0] now_r;

  logic [TIME_W-1:0] wind_dur_r;
  logic [TIME_W-1:0] shunt_dur_r;
  logic [TIME_W-1:0] unwind_dur_r;

  logic              out_valid_r;
  phase_t            phase_r;
  phase_t            phase_nxt;
  logic [TIME_W-1:0] stage_start_r;
  logic [TIME_W-1:0] stage_start_nxt;
  logic              armed_r;
  logic              armed_nxt;
  logic              magnet_r;
  logic              magnet_nxt;
  logic              latch_fwd_r;
  logic              latch_fwd_nxt;
  logic              latch_bwd_r;
  logic              latch_bwd_nxt;
  drive_t            drive_r;
  drive_t            drive_nxt;
  drive_t            mix_drive;

  logic              in_accept;
  logic              commit;
  logic              go;
  logic              released;
  phase_t            cur_phase;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] elapsed;

  assign in_accept = in_valid && !in_stall;
  assign commit    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (commit) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      thr_r   <= in_throttle_pot;
      trn_r   <= in_turn_pot;
      start_r <= in_start_button;
      rel_r   <= in_release_button;
      now_r   <= in_time_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_dur_r   <= WIND_RESET;
      shunt_dur_r  <= SHUNT_RESET;
      unwind_dur_r <= UNWIND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIND:   wind_dur_r   <= cfg_data;
        REG_SHUNT:  shunt_dur_r  <= cfg_data;
        REG_UNWIND: unwind_dur_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tasdm_mixer #(
    .POT_FULL_SCALE  (POT_FULL_SCALE),
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
  ) u_mixer (
    .throttle_pot (thr_r),
    .turn_pot     (trn_r),
    .drive        (mix_drive)
  );

  assign go        = start_r && (phase_r == PH_IDLE) && !armed_r;
  assign released  = rel_r && armed_r;
  assign cur_phase = go ? PH_WIND : phase_r;
  assign base_time = go ? now_r : stage_start_r;
  assign elapsed   = now_r - base_time;

  always_comb begin
    phase_nxt       = cur_phase;
    stage_start_nxt = base_time;
    unique case (cur_phase)
      PH_WIND: begin
        if (elapsed >= wind_dur_r) begin
          phase_nxt       = PH_SHUNT;
          stage_start_nxt = now_r;
        end
      end
      PH_SHUNT: begin
        if (elapsed >= shunt_dur_r) begin
          phase_nxt       = PH_UNWIND;
          stage_start_nxt = now_r;
        end
      end
      PH_UNWIND: begin
        if (elapsed >= unwind_dur_r) begin
          phase_nxt = PH_PRIMED;
        end
      end
      PH_PRIMED: phase_nxt = PH_IDLE;
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    armed_nxt     = released ? 1'b0 : armed_r;
    magnet_nxt    = released ? 1'b0 : magnet_r;
    latch_fwd_nxt = latch_fwd_r;
    latch_bwd_nxt = latch_bwd_r;
    drive_nxt     = drive_r;
    unique case (cur_phase)
      PH_WIND: begin
        latch_fwd_nxt = 1'b1;
        latch_bwd_nxt = 1'b0;
      end
      PH_SHUNT: begin
        latch_fwd_nxt = 1'b0;
        latch_bwd_nxt = 1'b0;
        magnet_nxt    = 1'b1;
      end
      PH_UNWIND: begin
        latch_fwd_nxt = 1'b0;
        latch_bwd_nxt = 1'b1;
        magnet_nxt    = 1'b1;
        if (elapsed >= unwind_dur_r) begin
          armed_nxt = 1'b1;
        end
      end
      PH_PRIMED: begin
        latch_fwd_nxt = 1'b0;
        latch_bwd_nxt = 1'b0;
        magnet_nxt    = 1'b1;
      end
      default: drive_nxt = mix_drive;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      stage_start_r <= '0;
      armed_r       <= 1'b0;
      magnet_r      <= 1'b0;
      latch_fwd_r   <= 1'b0;
      latch_bwd_r   <= 1'b0;
      drive_r       <= '{left_dir: DIR_STOP, left_duty: '0, right_dir: DIR_STOP,
                         right_duty: '0};
    end else if (commit) begin
      phase_r       <= phase_nxt;
      stage_start_r <= stage_start_nxt;
      armed_r       <= armed_nxt;
      magnet_r      <= magnet_nxt;
      latch_fwd_r   <= latch_fwd_nxt;
      latch_bwd_r   <= latch_bwd_nxt;
      drive_r       <= drive_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_phase_out       = phase_r;
  assign out_primed_out      = armed_r;
  assign out_magnet_on       = magnet_r;
  assign out_latch_forward   = latch_fwd_r;
  assign out_latch_backward  = latch_bwd_r;
  assign out_left_direction  = drive_r.left_dir;
  assign out_left_duty       = drive_r.left_duty;
  assign out_right_direction = drive_r.right_dir;
  assign out_right_duty      = drive_r.right_duty;

  a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with no pending transaction");

  a_primed_arms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && phase_r == PH_PRIMED |-> armed_r && magnet_r)
    else $error("primed result without armed latch and magnet");

  a_primed_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit && phase_r == PH_PRIMED |=> phase_r == PH_IDLE)
    else $error("primed phase did not return to idle");

  a_latch_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(latch_fwd_r && latch_bwd_r))
    else $error("latch motor driven both ways");

endmodule
